// File: rtl/grb_pkg.sv
// Shared types and constants of the grid region binner.
package grb_pkg;

    localparam int GRID_HALF_RANGE = 512;
    localparam int AXIS_INDEX_BITS = 10;
    localparam int COORD_W = 32;
    localparam int CELL_W = 20;
    localparam int VOL_W = 60;
    localparam int PACK_W = 3 * AXIS_INDEX_BITS;
    localparam logic [CELL_W-1:0] CELL_RESET = 20'd256000;

    // Configuration register indexes.
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_CELL_X   = 3'd3;
    localparam logic [2:0] REG_CELL_Y   = 3'd4;
    localparam logic [2:0] REG_CELL_Z   = 3'd5;

    localparam logic REQ_BOX   = 1'b0;
    localparam logic REQ_POINT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NULL   = 2'd1,
        ST_RANGE  = 2'd2,
        ST_NO_OVL = 2'd3
    } t_status;

    typedef struct packed {
        logic               req_type;
        logic               box_is_null;
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [31:0] max_z;
    } t_req;

    typedef struct packed {
        logic [1:0]                 status;
        logic [AXIS_INDEX_BITS-1:0] cell_x;
        logic [AXIS_INDEX_BITS-1:0] cell_y;
        logic [AXIS_INDEX_BITS-1:0] cell_z;
        logic [PACK_W-1:0]          packed_index;
        logic [VOL_W-1:0]           best_volume;
    } t_rsp;

endpackage

// File: rtl/grb_req_if.sv
// Request channel of the grid region binner.
interface grb_req_if;
    logic          valid;
    logic          ready;
    grb_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/grb_rsp_if.sv
// Result channel of the grid region binner.
interface grb_rsp_if;
    logic          valid;
    logic          ready;
    grb_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/grid_region_binner_top.sv
// Grid region binner: one request at a time; a point takes three 33-step serial divisions
// and a box six, all through one divider; a box then weighs up to three candidate cells
// per axis through one shared multiplier, and a three-pass volume product on the same
// multiplier. A finished result waits in an output register, and the next request is
// taken meanwhile.
module grid_region_binner_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [2:0]                   i_cfg_idx,
    input  logic [31:0]                  i_cfg_data,
    grb_req_if.sink                      i_req,
    grb_rsp_if.source                    o_rsp
);
    import grb_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_DIV_GO   = 12'b000000000010,
        S_DIV_WAIT = 12'b000000000100,
        S_W_INIT   = 12'b000000001000,
        S_W_MUL    = 12'b000000010000,
        S_W_BND    = 12'b000000100000,
        S_W_LEN    = 12'b000001000000,
        S_V0       = 12'b000010000000,
        S_V1       = 12'b000100000000,
        S_V2       = 12'b001000000000,
        S_V3       = 12'b010000000000,
        S_FIN      = 12'b100000000000
    } t_state;

    localparam int IW = AXIS_INDEX_BITS;

    t_state                 r_state;
    logic signed [31:0]     r_origin [3];
    logic [CELL_W-1:0]      r_cell [3];
    logic                   r_type;
    logic signed [31:0]     r_pmin [3];
    logic signed [31:0]     r_pmax [3];
    logic [2:0]             r_k;
    logic                   r_rerr;
    logic signed [IW-1:0]   r_lo [3];
    logic signed [IW-1:0]   r_hi [3];
    logic [1:0]             r_axis;
    logic [1:0]             r_cand;
    logic signed [IW-1:0]   r_cur;
    logic signed [IW-1:0]   r_best_i;
    logic [CELL_W-1:0]      r_best_len;
    logic signed [IW-1:0]   r_sel [3];
    logic [CELL_W-1:0]      r_len [3];
    logic signed [35:0]     r_a;
    logic signed [35:0]     r_b;
    logic [19:0]            r_phi;
    logic [VOL_W-1:0]       r_vol;
    t_status                r_status;
    t_rsp                   r_out;
    logic                   r_out_valid;

    logic [CELL_W-1:0]      den [3];
    logic [1:0]             dax;
    logic signed [31:0]     dp;
    logic signed [32:0]     dnum;
    logic                   div_start;
    logic                   div_done;
    logic signed [33:0]     div_quo;
    logic                   q_ok;
    logic signed [21:0]     mul_a;
    logic [CELL_W-1:0]      mul_b;
    logic signed [41:0]     prod;
    logic signed [35:0]     c0;
    logic signed [35:0]     c1;
    logic signed [35:0]     diff;
    logic [CELL_W-1:0]      cand_len;
    logic [CELL_W-1:0]      n_best_len;
    logic signed [IW-1:0]   n_best_i;
    logic signed [IW:0]     span;
    logic                   out_load;
    t_rsp                   rsp_next;
    logic [IW-1:0]          bx, by, bz;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            den[a] = (r_cell[a] == '0) ? CELL_W'(1) : r_cell[a];
        end
        dax  = (r_k >= 3'd3) ? 2'(r_k - 3'd3) : r_k[1:0];
        dp   = (r_k >= 3'd3) ? r_pmax[dax] : r_pmin[dax];
        dnum = {dp[31], dp} - {r_origin[dax][31], r_origin[dax]};
        div_start = (r_state == S_DIV_GO);
        q_ok = (div_quo[33:IW-1] == '0) || (div_quo[33:IW-1] == '1);
    end

    grb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (dnum),
        .i_den   (den[dax]),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_W_MUL: begin
                mul_a = 22'(r_cur);
                mul_b = den[r_axis];
            end
            S_V0: begin
                mul_a = $signed({2'b00, r_len[0]});
                mul_b = r_len[1];
            end
            S_V1: begin
                mul_a = $signed({2'b00, prod[19:0]});
                mul_b = r_len[2];
            end
            S_V2: begin
                mul_a = $signed({2'b00, r_phi});
                mul_b = r_len[2];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    grb_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Cell bounds and the overlap length of the current candidate.
    always_comb begin
        c0 = 36'(prod) + 36'(r_origin[r_axis]);
        c1 = c0 + $signed({16'd0, den[r_axis]});
        diff = r_b - r_a;
        cand_len = (diff > 0) ? diff[CELL_W-1:0] : '0;
        if (cand_len > r_best_len) begin
            n_best_len = cand_len;
            n_best_i   = r_cur;
        end else begin
            n_best_len = r_best_len;
            n_best_i   = r_best_i;
        end
        span = (IW+1)'(r_hi[r_axis]) - (IW+1)'(r_lo[r_axis]);
    end

    always_comb begin
        bx = {~r_sel[0][IW-1], r_sel[0][IW-2:0]};
        by = {~r_sel[1][IW-1], r_sel[1][IW-2:0]};
        bz = {~r_sel[2][IW-1], r_sel[2][IW-2:0]};
        rsp_next = '0;
        rsp_next.status = r_status;
        if (r_status == ST_OK) begin
            rsp_next.cell_x = bx;
            rsp_next.cell_y = by;
            rsp_next.cell_z = bz;
            rsp_next.packed_index = {bz, by, bx};
            rsp_next.best_volume = r_vol;
        end
        out_load = (r_state == S_FIN) && (!r_out_valid || o_rsp.ready);
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_origin[a] <= '0;
                r_cell[a]   <= CELL_RESET;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ORIGIN_X: r_origin[0] <= i_cfg_data;
                REG_ORIGIN_Y: r_origin[1] <= i_cfg_data;
                REG_ORIGIN_Z: r_origin[2] <= i_cfg_data;
                REG_CELL_X:   r_cell[0] <= i_cfg_data[CELL_W-1:0];
                REG_CELL_Y:   r_cell[1] <= i_cfg_data[CELL_W-1:0];
                REG_CELL_Z:   r_cell[2] <= i_cfg_data[CELL_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out       <= rsp_next;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_type    <= i_req.data.req_type;
                        r_pmin[0] <= i_req.data.min_x;
                        r_pmin[1] <= i_req.data.min_y;
                        r_pmin[2] <= i_req.data.min_z;
                        r_pmax[0] <= i_req.data.max_x;
                        r_pmax[1] <= i_req.data.max_y;
                        r_pmax[2] <= i_req.data.max_z;
                        r_k       <= '0;
                        r_rerr    <= 1'b0;
                        r_vol     <= '0;
                        r_axis    <= '0;
                        if (i_req.data.req_type == REQ_BOX && i_req.data.box_is_null) begin
                            r_status <= ST_NULL;
                            r_state  <= S_FIN;
                        end else begin
                            r_status <= ST_OK;
                            r_state  <= S_DIV_GO;
                        end
                    end
                end
                S_DIV_GO: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (div_done) begin
                        if (r_k >= 3'd3) begin
                            r_hi[dax] <= div_quo[IW-1:0];
                        end else begin
                            r_lo[dax] <= div_quo[IW-1:0];
                            r_sel[dax] <= div_quo[IW-1:0];
                        end
                        if ((r_type == REQ_POINT && r_k == 3'd2) || r_k == 3'd5) begin
                            if (r_rerr || !q_ok) begin
                                r_status <= ST_RANGE;
                                r_state  <= S_FIN;
                            end else if (r_type == REQ_POINT) begin
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_W_INIT;
                            end
                        end else begin
                            r_rerr  <= r_rerr || !q_ok;
                            r_k     <= r_k + 3'd1;
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_W_INIT: begin
                    r_best_i   <= r_lo[r_axis];
                    r_best_len <= '0;
                    r_cur      <= r_lo[r_axis];
                    r_cand     <= '0;
                    // An inverted index range covers no cell at all.
                    if (span[IW]) begin
                        r_status <= ST_NO_OVL;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_W_MUL;
                    end
                end
                S_W_MUL: r_state <= S_W_BND;
                S_W_BND: begin
                    r_a <= (36'(r_pmin[r_axis]) > c0) ? 36'(r_pmin[r_axis]) : c0;
                    r_b <= (36'(r_pmax[r_axis]) < c1) ? 36'(r_pmax[r_axis]) : c1;
                    r_state <= S_W_LEN;
                end
                S_W_LEN: begin
                    r_best_len <= n_best_len;
                    r_best_i   <= n_best_i;
                    // Cells strictly inside the range all overlap by a full cell, so
                    // the first, second and last cells decide the best one.
                    if (r_cand == 2'd0 && span > 0) begin
                        r_cur   <= r_cur + IW'(1);
                        r_cand  <= 2'd1;
                        r_state <= S_W_MUL;
                    end else if (r_cand == 2'd1 && span > 1) begin
                        r_cur   <= r_hi[r_axis];
                        r_cand  <= 2'd2;
                        r_state <= S_W_MUL;
                    end else if (n_best_len == '0) begin
                        r_status <= ST_NO_OVL;
                        r_state  <= S_FIN;
                    end else begin
                        r_len[r_axis] <= n_best_len;
                        r_sel[r_axis] <= n_best_i;
                        if (r_axis == 2'd2) begin
                            r_state <= S_V0;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= S_W_INIT;
                        end
                    end
                end
                S_V0: r_state <= S_V1;
                S_V1: begin
                    r_phi   <= prod[39:20];
                    r_state <= S_V2;
                end
                S_V2: begin
                    r_vol   <= VOL_W'(prod[39:0]);
                    r_state <= S_V3;
                end
                S_V3: begin
                    r_vol   <= r_vol + VOL_W'({prod[39:0], 20'd0});
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/grb_div.sv
// Radix-2 restoring divider that returns the floored signed quotient.
module grb_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [32:0]            i_num,
    input  logic [grb_pkg::CELL_W-1:0]    i_den,
    output logic                          o_done,
    output logic signed [33:0]            o_quo
);
    import grb_pkg::*;

    logic [32:0]       r_quo;
    logic [CELL_W-1:0] r_rem;
    logic [5:0]        r_cnt;
    logic              r_neg;
    logic              r_busy;
    logic              r_done;
    logic [CELL_W:0]   rem_sh;
    logic              ge;
    logic [CELL_W-1:0] n_rem;
    logic [33:0]       qm;

    always_comb begin
        rem_sh = {r_rem, r_quo[32]};
        ge     = rem_sh >= {1'b0, i_den};
        n_rem  = ge ? CELL_W'(rem_sh - {1'b0, i_den}) : rem_sh[CELL_W-1:0];
        qm     = {1'b0, r_quo};
        // Floor toward minus infinity for a negative dividend with a remainder.
        if (r_neg) begin
            o_quo = $signed(-qm - 34'(r_rem != '0));
        end else begin
            o_quo = $signed(qm);
        end
    end

    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_num[32] ? 33'(-i_num) : 33'(i_num);
                r_rem  <= '0;
                r_neg  <= i_num[32];
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[31:0], ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd32) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

// File: rtl/grb_mul.sv
// Shared multiplier with a registered product.
module grb_mul (
    input  logic                        i_clk,
    input  logic signed [21:0]          i_a,
    input  logic [grb_pkg::CELL_W-1:0]  i_b,
    output logic signed [41:0]          o_prod
);
    import grb_pkg::*;

    logic signed [41:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * $signed({1'b0, i_b});
    end

    assign o_prod = r_prod;
endmodule

// File: bench/grb_result_checker.sv
// Result checker of the grid region binner: predicts each request's result and compares it.
module grb_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    grb_req_if          req,
    grb_rsp_if          rsp,
    output int          o_fail_cnt,
    output int          o_pending
);
    import grb_pkg::*;

    logic signed [31:0] grid_origin [3];
    logic [CELL_W-1:0]  grid_cell [3];
    t_rsp               cells_due [$];

    function automatic longint floor_div(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint cell_edge(input int a);
        return (grid_cell[a] == '0) ? 1 : longint'(grid_cell[a]);
    endfunction

    function automatic longint cell_of(input longint p, input int a);
        return floor_div(p - longint'(grid_origin[a]), cell_edge(a));
    endfunction

    function automatic bit index_ok(input longint i);
        return i >= -GRID_HALF_RANGE && i <= GRID_HALF_RANGE - 1;
    endfunction

    // Interior cells are all fully covered, so the first one is the only interior
    // candidate; the two end cells can be partial.
    function automatic void axis_overlap(input int a, input longint bmin, input longint bmax,
                                         input longint lo, input longint hi,
                                         output longint sel, output longint len);
        longint cand [3];
        longint d, c0, c1, lft, rgt, l;
        d = cell_edge(a);
        cand[0] = lo;
        cand[1] = lo + 1;
        cand[2] = hi;
        sel = lo;
        len = 0;
        for (int k = 0; k < 3; k++) begin
            if (cand[k] <= hi) begin
                c0 = cand[k] * d + longint'(grid_origin[a]);
                c1 = c0 + d;
                lft = (bmin > c0) ? bmin : c0;
                rgt = (bmax < c1) ? bmax : c1;
                l = (rgt > lft) ? rgt - lft : 0;
                if (l > len) begin
                    len = l;
                    sel = cand[k];
                end
            end
        end
    endfunction

    function automatic t_rsp bin_request(input t_req r);
        t_rsp   res;
        longint lo_c [3];
        longint hi_c [3];
        longint imin [3];
        longint imax [3];
        longint sel [3];
        longint len [3];
        logic [AXIS_INDEX_BITS-1:0] biased [3];
        logic [VOL_W-1:0] vol;
        res = '0;
        vol = '0;
        lo_c[0] = r.min_x; lo_c[1] = r.min_y; lo_c[2] = r.min_z;
        hi_c[0] = r.max_x; hi_c[1] = r.max_y; hi_c[2] = r.max_z;
        if (r.req_type == REQ_POINT) begin
            for (int a = 0; a < 3; a++) begin
                sel[a] = cell_of(lo_c[a], a);
                if (!index_ok(sel[a])) begin
                    res.status = ST_RANGE;
                    return res;
                end
            end
        end else begin
            if (r.box_is_null) begin
                res.status = ST_NULL;
                return res;
            end
            for (int a = 0; a < 3; a++) begin
                imin[a] = cell_of(lo_c[a], a);
                imax[a] = cell_of(hi_c[a], a);
                if (!index_ok(imin[a]) || !index_ok(imax[a])) begin
                    res.status = ST_RANGE;
                    return res;
                end
            end
            for (int a = 0; a < 3; a++) begin
                axis_overlap(a, lo_c[a], hi_c[a], imin[a], imax[a], sel[a], len[a]);
                if (len[a] <= 0) begin
                    res.status = ST_NO_OVL;
                    return res;
                end
            end
            vol = VOL_W'(len[0]) * VOL_W'(len[1]) * VOL_W'(len[2]);
        end
        for (int a = 0; a < 3; a++)
            biased[a] = AXIS_INDEX_BITS'(sel[a] + GRID_HALF_RANGE);
        res.status = ST_OK;
        res.cell_x = biased[0];
        res.cell_y = biased[1];
        res.cell_z = biased[2];
        res.packed_index = {biased[2], biased[1], biased[0]};
        res.best_volume = vol;
        return res;
    endfunction

    assign o_pending = cells_due.size();

    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                grid_origin[a] <= '0;
                grid_cell[a] <= CELL_RESET;
            end
            o_fail_cnt <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ORIGIN_X: grid_origin[0] <= i_cfg_data;
                    REG_ORIGIN_Y: grid_origin[1] <= i_cfg_data;
                    REG_ORIGIN_Z: grid_origin[2] <= i_cfg_data;
                    REG_CELL_X:   grid_cell[0] <= i_cfg_data[CELL_W-1:0];
                    REG_CELL_Y:   grid_cell[1] <= i_cfg_data[CELL_W-1:0];
                    REG_CELL_Z:   grid_cell[2] <= i_cfg_data[CELL_W-1:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
                cells_due = {cells_due, bin_request(req.data)};
            if (rsp.valid && rsp.ready) begin
                got = rsp.data;
                if (cells_due.size() == 0) begin
                    if (o_fail_cnt < 10)
                        $display("unexpected result beat: %p", got);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    want = cells_due.pop_front();
                    if (got.status !== want.status || got.cell_x !== want.cell_x ||
                        got.cell_y !== want.cell_y || got.cell_z !== want.cell_z ||
                        got.packed_index !== want.packed_index ||
                        got.best_volume !== want.best_volume) begin
                        if (o_fail_cnt < 10)
                            $display("result mismatch: expected %p, got %p", want, got);
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                end
            end
        end
    end
endmodule

// File: bench/tb_grid_region_binner_top.sv
// Stimulus and verdict for the grid region binner, with the result checker alongside.
module tb_grid_region_binner_top;
    import grb_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    int          fail_cnt;
    int          pending;
    int          idle_cycles;
    bit          calm_send;
    bit          calm_recv;
    longint      sh_origin [3];
    longint      sh_cell [3];

    grb_req_if req_ch ();
    grb_rsp_if rsp_ch ();

    grid_region_binner_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    grb_result_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: a random stall before some beats, with quiet stretches.
    initial begin
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm_recv && $urandom_range(0, 1)) begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge i_clk);
            end
            rsp_ch.ready = 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            if ($urandom_range(0, 99) < 2)
                calm_recv = !calm_recv;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input longint val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val[31:0];
        if (idx >= REG_CELL_X)
            sh_cell[idx - REG_CELL_X] = (val[19:0] == 0) ? 1 : longint'(val[19:0]);
        else
            sh_origin[idx] = longint'(signed'(val[31:0]));
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic send(input t_req r);
        if (!calm_send) begin
            int gap;
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                req_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        req_ch.valid = 1'b1;
        req_ch.data = r;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < 2)
            calm_send = !calm_send;
    endtask

    // Coordinate inside cell idx of an axis, frac raw units past the cell's lower edge.
    function automatic logic [31:0] coord_at(input int a, input longint idx, input longint frac);
        longint v;
        v = sh_origin[a] + idx * sh_cell[a] + frac;
        return v[31:0];
    endfunction

    function automatic longint pick_frac(input int a);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return sh_cell[a] - 1;
            default: return longint'($urandom_range(0, 32'(sh_cell[a] - 1)));
        endcase
    endfunction

    function automatic longint pick_index();
        if ($urandom_range(0, 9) == 0)
            return longint'($urandom_range(0, 9)) - 517 + ($urandom_range(0, 1) ? 1026 : 0);
        return longint'($urandom_range(0, 1023)) - 512;
    endfunction

    function automatic t_req random_req();
        t_req r;
        int sel;
        logic [31:0] lo [3];
        logic [31:0] hi [3];
        longint i0, span;
        r.req_type = REQ_BOX;
        r.box_is_null = 1'b0;
        sel = $urandom_range(0, 99);
        for (int a = 0; a < 3; a++) begin
            i0 = pick_index();
            case ($urandom_range(0, 9))
                0: span = -1;
                1: span = $urandom_range(3, 40);
                default: span = $urandom_range(0, 2);
            endcase
            lo[a] = coord_at(a, i0, pick_frac(a));
            hi[a] = ($urandom_range(0, 29) == 0) ? lo[a] : coord_at(a, i0 + span, pick_frac(a));
        end
        r.min_x = lo[0]; r.min_y = lo[1]; r.min_z = lo[2];
        r.max_x = hi[0]; r.max_y = hi[1]; r.max_z = hi[2];
        if (sel < 15) begin
            r.req_type = REQ_POINT;
            r.box_is_null = 1'($urandom_range(0, 1));
            r.max_x = $urandom; r.max_y = $urandom; r.max_z = $urandom;
        end else if (sel < 20) begin
            r.box_is_null = 1'b1;
        end else if (sel < 30) begin
            r = $bits(t_req)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom});
        end
        return r;
    endfunction

    function automatic t_req box_of(input longint ix0, input longint ix1, input longint f0,
                                    input longint f1);
        t_req r;
        r.req_type = REQ_BOX;
        r.box_is_null = 1'b0;
        r.min_x = coord_at(0, ix0, f0); r.max_x = coord_at(0, ix1, f1);
        r.min_y = coord_at(1, ix0, f0); r.max_y = coord_at(1, ix1, f1);
        r.min_z = coord_at(2, ix0, f0); r.max_z = coord_at(2, ix1, f1);
        return r;
    endfunction

    task automatic directed_items();
        t_req r;
        longint d;
        d = sh_cell[0];
        r = box_of(0, 0, 0, 0);
        r.req_type = REQ_POINT;
        send(r);
        r = box_of(-512, -512, 0, 0);
        r.req_type = REQ_POINT;
        r.box_is_null = 1'b1;
        send(r);
        r = box_of(511, 511, d - 1, 0);
        r.req_type = REQ_POINT;
        send(r);
        r = box_of(512, 0, 0, 0);
        r.req_type = REQ_POINT;
        send(r);
        r = box_of(-513, 0, d - 1, 0);
        r.req_type = REQ_POINT;
        send(r);
        r = box_of(3, 4, 10, 20);
        r.box_is_null = 1'b1;
        send(r);
        send(box_of(5, 5, 10, d - 3));
        send(box_of(-2, 0, d / 2, d / 3));
        send(box_of(-512, 511, 0, d - 1));
        send(box_of(-512, 511, d - 1, 0));
        send(box_of(7, 4, 0, 0));
        send(box_of(6, 6, 100, 100));
        // The box ends exactly on a cell edge, so the upper cell only touches it.
        send(box_of(2, 3, 0, 0));
        send(box_of(-3, -1, d - 1, 1));
        send(box_of(511, 512, 0, 0));
        send(box_of(-513, -512, d - 1, 0));
        r = '0;
        r.min_x = 32'h8000_0000; r.min_y = 32'h8000_0000; r.min_z = 32'h8000_0000;
        r.max_x = 32'h7fff_ffff; r.max_y = 32'h7fff_ffff; r.max_z = 32'h7fff_ffff;
        send(r);
        r.req_type = REQ_POINT;
        send(r);
        r = '1;
        send(r);
        r.req_type = REQ_BOX;
        send(r);
    endtask

    initial begin
        longint org [6][3];
        longint csz [6][3];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_ORIGIN_X;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        idle_cycles = 0;
        calm_send = 1'b0;
        calm_recv = 1'b0;
        for (int a = 0; a < 3; a++) begin
            sh_origin[a] = 0;
            sh_cell[a] = CELL_RESET;
        end
        org = '{'{0, 0, 0}, '{2147483647, -2147483648, 12345},
                '{-2147483648, 2147483647, -777}, '{-1000, 0, 2147483647},
                '{0, 5000, -300}, '{99, -99, 0}};
        csz = '{'{256000, 256000, 256000}, '{1048575, 1048575, 1048575},
                '{1, 1, 1}, '{0, 1048575, 37}, '{1000, 256, 65536}, '{3, 4000, 1048575}};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        directed_items();
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                wait_drained();
                for (int a = 0; a < 3; a++) begin
                    write_reg(3'(REG_ORIGIN_X + a), org[ph][a]);
                    write_reg(3'(REG_CELL_X + a), csz[ph][a]);
                end
            end
            repeat (280) send(random_req());
            if (ph == 3) begin
                // Let the pipeline run dry before the rest of this phase.
                req_ch.valid = 1'b0;
                while (pending != 0)
                    @(negedge i_clk);
                repeat (20) send(random_req());
            end
        end
        req_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
